[rtl/assert_macros.svh]
// Assertion macros shared by the calendar conversion RTL.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[rtl/esc_pkg.sv]
// Types, constants and the microcode table of the epoch to calendar converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package esc_pkg;

    typedef struct packed {
        logic [30:0] epoch_seconds;
        logic [9:0]  millis_in;
    } t_in_item;

    typedef struct packed {
        logic [5:0] second_of_minute;
        logic [5:0] minute_of_hour;
        logic [4:0] hour_of_day;
        logic [4:0] day_of_month;
        logic [3:0] month_of_year;
        logic [6:0] years_since_1970;
        logic [9:0] millis_out;
    } t_out_item;

    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_DAY,
        OP_DIV_MIN,
        OP_SPLIT_DAY,
        OP_SPLIT_MIN,
        OP_SPLIT_HOUR,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_YEAR_FIT,
        C_MONTH_FIT,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
    } t_dp_flags;

    typedef struct packed {
        logic      in_valid;
        logic      out_busy;
        t_dp_flags dp;
    } t_seq_status;

    // Program addresses
    localparam logic [PC_W-1:0] A_LOAD       = 4'd0;
    localparam logic [PC_W-1:0] A_DIV_DAY    = 4'd1;
    localparam logic [PC_W-1:0] A_SPLIT_DAY  = 4'd2;
    localparam logic [PC_W-1:0] A_DIV_SOD    = 4'd3;
    localparam logic [PC_W-1:0] A_SPLIT_MIN  = 4'd4;
    localparam logic [PC_W-1:0] A_DIV_MINS   = 4'd5;
    localparam logic [PC_W-1:0] A_SPLIT_HOUR = 4'd6;
    localparam logic [PC_W-1:0] A_YEAR       = 4'd7;
    localparam logic [PC_W-1:0] A_MONTH      = 4'd8;
    localparam logic [PC_W-1:0] A_EMIT       = 4'd9;
    localparam logic [PC_W-1:0] A_RESTART    = 4'd10;

    localparam logic [16:0] DAY_SECS      = 17'd86400;
    localparam logic [16:0] MIN_SECS      = 17'd60;
    localparam logic [8:0]  YEAR_LEN      = 9'd365;
    localparam logic [8:0]  LEAP_YEAR_LEN = 9'd366;
    localparam logic [1:0]  LEAP_PHASE    = 2'd2;   // 1970 + n is leap when n mod 4 is 2
    localparam logic [3:0]  LAST_MONTH    = 4'd11;

    // Reciprocals for the divisions by constants. Days are ((secs >> 7) * DAY_RECIP) >> 34
    // and x / 60 is ((x >> 2) * MIN_RECIP) >> 19; both are exact over the ranges used.
    localparam logic [24:0] DAY_RECIP = 25'd25451659;
    localparam logic [15:0] MIN_RECIP = 16'd34953;

    function automatic t_ctrl ucode_word(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: A_LOAD};
        case (pc)
            A_LOAD:       w = '{op: OP_LOAD,       cond: C_NO_INPUT,  target: A_LOAD};
            A_DIV_DAY:    w = '{op: OP_DIV_DAY,    cond: C_NEXT,      target: A_LOAD};
            A_SPLIT_DAY:  w = '{op: OP_SPLIT_DAY,  cond: C_NEXT,      target: A_LOAD};
            A_DIV_SOD:    w = '{op: OP_DIV_MIN,    cond: C_NEXT,      target: A_LOAD};
            A_SPLIT_MIN:  w = '{op: OP_SPLIT_MIN,  cond: C_NEXT,      target: A_LOAD};
            A_DIV_MINS:   w = '{op: OP_DIV_MIN,    cond: C_NEXT,      target: A_LOAD};
            A_SPLIT_HOUR: w = '{op: OP_SPLIT_HOUR, cond: C_NEXT,      target: A_LOAD};
            A_YEAR:       w = '{op: OP_YEAR,       cond: C_YEAR_FIT,  target: A_YEAR};
            A_MONTH:      w = '{op: OP_MONTH,      cond: C_MONTH_FIT, target: A_MONTH};
            A_EMIT:       w = '{op: OP_EMIT,       cond: C_OUT_BUSY,  target: A_EMIT};
            A_RESTART:    w = '{op: OP_NOP,        cond: C_ALWAYS,    target: A_LOAD};
            default:      w = '{op: OP_NOP,        cond: C_ALWAYS,    target: A_LOAD};
        endcase
        return w;
    endfunction

    // Month index counts from zero (January).
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[rtl/esc_sequencer.sv]
// Step counter of the calendar converter: fetches the control word and resolves jumps.
// Depends on esc_pkg for the microcode table and control types.
`default_nettype none

module esc_sequencer
    import esc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_seq_status i_status,
    output t_ctrl       o_ctrl
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           ctrl;
    logic            take;

    always_comb begin
        ctrl = ucode_word(r_pc);
        case (ctrl.cond)
            C_NEXT:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_INPUT:  take = !i_status.in_valid;
            C_YEAR_FIT:  take = i_status.dp.year_fit;
            C_MONTH_FIT: take = i_status.dp.month_fit;
            C_OUT_BUSY:  take = i_status.out_busy;
            default:     take = 1'b0;
        endcase
        n_pc = take ? ctrl.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = ctrl;

endmodule

`default_nettype wire

[rtl/esc_datapath.sv]
// Datapath of the calendar converter: reciprocal division, year and month subtraction.
// Depends on esc_pkg; driven one control word per cycle by esc_sequencer.
`default_nettype none

module esc_datapath
    import esc_pkg::*;
(
    input  wire       i_clk,
    input  t_ctrl     i_ctrl,
    input  wire       i_in_valid,
    input  t_in_item  i_in_data,
    output t_dp_flags o_flags,
    output t_out_item o_result
);

    logic [30:0] r_acc, n_acc;
    logic [14:0] r_days, n_days;
    logic [10:0] r_quot, n_quot;
    logic [5:0]  r_sec, n_sec;
    logic [5:0]  r_min, n_min;
    logic [4:0]  r_hour, n_hour;
    logic [6:0]  r_year, n_year;
    logic [3:0]  r_mon, n_mon;
    logic [9:0]  r_ms, n_ms;

    logic [48:0] day_recip_prod;
    logic [31:0] day_back_prod;
    logic [31:0] min_recip_prod;
    logic [16:0] min_back_prod;
    logic [16:0] rem60;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic        year_fit;
    logic        month_fit;

    always_comb begin
        // Quotients come from multiplying by a scaled reciprocal; remainders by multiplying
        // the quotient back and subtracting.
        day_recip_prod = {25'd0, r_acc[30:7]} * {24'd0, DAY_RECIP};
        day_back_prod  = {17'd0, r_days} * {15'd0, DAY_SECS};
        min_recip_prod = {17'd0, r_acc[16:2]} * {16'd0, MIN_RECIP};
        min_back_prod  = {6'd0, r_quot} * MIN_SECS;
        rem60          = r_acc[16:0] - min_back_prod;
        leap      = (r_year[1:0] == LEAP_PHASE);
        ylen      = leap ? LEAP_YEAR_LEN : YEAR_LEN;
        mlen      = month_len(r_mon, leap);
        year_fit  = (r_days >= {6'd0, ylen});
        month_fit = (r_days >= {10'd0, mlen}) && (r_mon < LAST_MONTH);

        n_acc  = r_acc;
        n_days = r_days;
        n_quot = r_quot;
        n_sec  = r_sec;
        n_min  = r_min;
        n_hour = r_hour;
        n_year = r_year;
        n_mon  = r_mon;
        n_ms   = r_ms;

        case (i_ctrl.op)
            OP_LOAD: begin
                if (i_in_valid) begin
                    n_acc = i_in_data.epoch_seconds;
                    n_ms  = i_in_data.millis_in;
                end
            end
            OP_DIV_DAY: begin
                n_days = day_recip_prod[48:34];
            end
            OP_SPLIT_DAY: begin
                // What is left is the second of the day.
                n_acc = r_acc - day_back_prod[30:0];
            end
            OP_DIV_MIN: begin
                n_quot = min_recip_prod[29:19];
            end
            OP_SPLIT_MIN: begin
                n_sec = rem60[5:0];
                n_acc = {20'd0, r_quot};
            end
            OP_SPLIT_HOUR: begin
                n_min  = rem60[5:0];
                n_hour = r_quot[4:0];
                n_year = '0;
                n_mon  = '0;
            end
            OP_YEAR: begin
                if (year_fit) begin
                    n_days = r_days - {6'd0, ylen};
                    n_year = r_year + 1'b1;
                end
            end
            OP_MONTH: begin
                if (month_fit) begin
                    n_days = r_days - {10'd0, mlen};
                    n_mon  = r_mon + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_days <= n_days;
        r_quot <= n_quot;
        r_sec  <= n_sec;
        r_min  <= n_min;
        r_hour <= n_hour;
        r_year <= n_year;
        r_mon  <= n_mon;
        r_ms   <= n_ms;
    end

    assign o_flags.year_fit  = year_fit;
    assign o_flags.month_fit = month_fit;

    assign o_result.second_of_minute = r_sec;
    assign o_result.minute_of_hour   = r_min;
    assign o_result.hour_of_day      = r_hour;
    assign o_result.day_of_month     = r_days[4:0] + 5'd1;
    assign o_result.month_of_year    = r_mon + 4'd1;
    assign o_result.years_since_1970 = r_year;
    assign o_result.millis_out       = r_ms;

endmodule

`default_nettype wire

[rtl/epoch_seconds_to_calendar_core.sv]
// Top level of the epoch seconds to calendar date converter.
// Depends on esc_pkg, esc_sequencer, esc_datapath and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Usage
// The input channel (i_in_valid / o_in_ready / i_in_data) carries one transaction per
// conversion: a count of seconds since 1970-01-01 00:00:00 and a millisecond value.
// The output channel (o_out_valid / i_out_ready / o_out_data) returns one transaction
// per input with second, minute, hour, day, month, year offset and the milliseconds.
// The block works on one transaction at a time. A small microprogram walks a shared
// datapath: six steps split the count into days, minutes, hours and seconds by
// reciprocal multiplication, then a year loop and a month loop take off whole years
// after 1970 and whole months, one per step, each loop ending with a step that finds
// no fit. The emit step then registers the result, and a restart step leads back to
// the accept step. The loop lengths follow the year offset Y and the zero-based
// month M.
// The result sits in an output register; if the receiver stalls, the sequencer waits
// at its emit step until that register is taken, and no input is accepted meanwhile.
// Reset (synchronous, active low) returns the sequencer to its accept step and
// empties the output register. The block keeps no state between transactions.

module epoch_seconds_to_calendar_core
    import esc_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    output t_out_item o_out_data
);

    t_ctrl       ctrl;
    t_dp_flags   flags;
    t_seq_status status;
    t_out_item   result;

    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_data;
    logic        out_busy;
    logic        emit_fire;
    logic        out_in_range;

    // The output register is free when empty or being taken in this cycle.
    assign out_busy  = r_out_valid && !i_out_ready;
    assign emit_fire = (ctrl.op == OP_EMIT) && !out_busy;

    assign status.in_valid = i_in_valid;
    assign status.out_busy = out_busy;
    assign status.dp       = flags;

    esc_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    esc_datapath u_dp (
        .i_clk      (i_clk),
        .i_ctrl     (ctrl),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_flags    (flags),
        .o_result   (result)
    );

    // Input is taken only while the program sits at its accept step.
    assign o_in_ready = (ctrl.op == OP_LOAD);

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign out_in_range = (o_out_data.month_of_year >= 4'd1)
                       && (o_out_data.month_of_year <= 4'd12)
                       && (o_out_data.hour_of_day <= 5'd23)
                       && (o_out_data.minute_of_hour <= 6'd59)
                       && (o_out_data.second_of_minute <= 6'd59)
                       && (o_out_data.day_of_month != 5'd0);

    // Once a transaction is taken the sequencer leaves its accept step.
    `ASSERT_PROP(a_accept_leaves, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)
    // A new result is never written over one that the receiver has not taken.
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, emit_fire && out_busy)
    // Presented results lie in the calendar's ranges.
    `ASSERT_PROP(a_result_range, i_clk, i_rst_n, o_out_valid |-> out_in_range)

endmodule

`default_nettype wire
